// ===== rtl/bcdq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcdq_pkg
// shared types and constants of the bounded circular deque
// ----------------------------------------------------------------------------
package bcdq_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int CMD_W     = 3;
	localparam int VALUE_W   = 32;
	localparam int COUNT_W   = 5;
	localparam int CAP_W     = 5;
	localparam int PDATA_W   = 32;
	localparam int PADDR_W   = 3;

	localparam logic [CAP_W-1:0] CAP_RESET    = CAP_W'(16);
	localparam logic [0:0]       REG_CAPACITY = 1'b0;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_REAR  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_REAR   = 3'd3,
		CMD_PEEK       = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                      accepted;
		logic signed [VALUE_W-1:0] front_value;
		logic signed [VALUE_W-1:0] rear_value;
		logic                      is_empty;
		logic                      is_full;
		logic [COUNT_W-1:0]        count;
	} res_t;

endpackage
`default_nettype wire

// ===== rtl/bcdq_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcdq request / response channels
// valid-ready channels carrying the deque command and its result
// ----------------------------------------------------------------------------
interface bcdq_req_if import bcdq_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          cmd;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output cmd, output value, input ready);
	modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface bcdq_rsp_if import bcdq_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      accepted;
	logic signed [VALUE_W-1:0] front_value;
	logic signed [VALUE_W-1:0] rear_value;
	logic                      is_empty;
	logic                      is_full;
	logic [COUNT_W-1:0]        count;

	modport source (output valid, output accepted, output front_value, output rear_value,
		output is_empty, output is_full, output count, input ready);
	modport sink   (input valid, input accepted, input front_value, input rear_value,
		input is_empty, input is_full, input count, output ready);
endinterface
`default_nettype wire

// ===== rtl/bcdq_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcdq_ram
// single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
module bcdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/bcdq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcdq_ctrl
// ring pointers, count and sequencer around the two ring ram copies
// ----------------------------------------------------------------------------
module bcdq_ctrl import bcdq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [CAP_W-1:0]   capacity,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire logic [CMD_W-1:0]   req_cmd,
	input  wire logic [VALUE_W-1:0] req_value,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output res_t                    res
);

	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	state_t             state_q, state_d;
	logic [IDX_W-1:0]   front_q, front_d;
	logic [IDX_W-1:0]   rear_q, rear_d;
	logic [CNT_W-1:0]   count_q, count_d;
	logic               ok_q, ok_d;
	logic               we;
	logic               re;
	logic [IDX_W-1:0]   waddr;
	logic [CW-1:0]      cap_x;
	logic [CW-1:0]      cap_eff;
	logic [CW-1:0]      count_x;
	logic [VALUE_W-1:0] rdata_f;
	logic [VALUE_W-1:0] rdata_r;
	logic               empty;

	function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
		return (i == '0) ? IDX_W'(DEPTH - 1) : i - IDX_W'(1);
	endfunction

	// capacity of zero acts as one, above the ring size as the ring size
	always_comb begin
		cap_x = CW'(capacity);
		if (cap_x == '0) begin
			cap_eff = CW'(1);
		end else if (cap_x > CW'(DEPTH)) begin
			cap_eff = CW'(DEPTH);
		end else begin
			cap_eff = cap_x;
		end
	end

	assign count_x = CW'(count_q);
	assign empty   = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			front_q <= '0;
			rear_q  <= '0;
			count_q <= '0;
			ok_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			rear_q  <= rear_d;
			count_q <= count_d;
			ok_q    <= ok_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		front_d   = front_q;
		rear_d    = rear_q;
		count_d   = count_q;
		ok_d      = ok_q;
		we        = 1'b0;
		waddr     = front_q;
		re        = 1'b0;
		req_ready = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ok_d    = 1'b0;
					state_d = ST_READ;
					case (cmd_t'(req_cmd))
						CMD_PUSH_FRONT, CMD_PUSH_REAR: begin
							if (empty) begin
								// first entry lands at the front slot
								rear_d  = front_q;
								we      = 1'b1;
								waddr   = front_q;
								count_d = CNT_W'(1);
								ok_d    = 1'b1;
							end else if (count_x < cap_eff) begin
								if (cmd_t'(req_cmd) == CMD_PUSH_FRONT) begin
									front_d = ring_prev(front_q);
									waddr   = ring_prev(front_q);
								end else begin
									rear_d = ring_next(rear_q);
									waddr  = ring_next(rear_q);
								end
								we      = 1'b1;
								count_d = count_q + CNT_W'(1);
								ok_d    = 1'b1;
							end
						end
						CMD_POP_FRONT, CMD_POP_REAR: begin
							if (!empty) begin
								// last entry leaves the pointers in place
								if (count_q != CNT_W'(1)) begin
									if (cmd_t'(req_cmd) == CMD_POP_FRONT) begin
										front_d = ring_next(front_q);
									end else begin
										rear_d = ring_prev(rear_q);
									end
								end
								count_d = count_q - CNT_W'(1);
								ok_d    = 1'b1;
							end
						end
						CMD_PEEK: begin
							ok_d = 1'b1;
						end
						default: begin
							ok_d = 1'b0;
						end
					endcase
				end
			end
			ST_READ: begin
				re      = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// two copies of the ring so front and rear read in the same cycle
	bcdq_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_front (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (req_value),
		.re    (re),
		.raddr (front_q),
		.rdata (rdata_f)
	);

	bcdq_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_rear (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (req_value),
		.re    (re),
		.raddr (rear_q),
		.rdata (rdata_r)
	);

	always_comb begin
		res.accepted    = ok_q;
		res.front_value = empty ? '1 : $signed(rdata_f);
		res.rear_value  = empty ? '1 : $signed(rdata_r);
		res.is_empty    = empty;
		res.is_full     = (count_x >= cap_eff);
		res.count       = count_x[COUNT_W-1:0];
	end

endmodule
`default_nettype wire

// ===== rtl/bounded_circular_deque.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_circular_deque
// double-ended queue in a ring buffer, bounded by a capacity register
// ----------------------------------------------------------------------------
// usage
//   req carries one request: cmd (push front, push rear, pop front, pop rear,
//   peek) and a 32-bit signed value used by the pushes. every request gives
//   exactly one result on rsp: accepted flag, front and rear values after the
//   request (-1 when empty), empty and full flags and the entry count.
//   a push into a full deque or a pop from an empty one is refused.
//   the capacity register sits at byte address 0 of the apb-style port,
//   reset value 16; program it only while no request is in flight.
// timing
//   a request is taken in the idle state (pointer update, ring write), the ring
//   is read in the read state and the result register loads from the done
//   state once the output register is free; a new request is taken only after
//   the result of the last one has moved into the output register.
// reset and stalls
//   arst_n clears pointers, count and the sequencer; capacity returns to 16.
//   the ring itself is not cleared, only written entries ever reach the result.
//   the result sits in an output register; while rsp.ready is low the next
//   request is still taken and worked up to the read, then waits for the
//   output register to free up.
// ----------------------------------------------------------------------------
module bounded_circular_deque import bcdq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	bcdq_req_if.sink                req,
	bcdq_rsp_if.source              rsp,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	logic [CAP_W-1:0] capacity_q;
	logic [0:0]       reg_idx;
	logic             cfg_wr;
	logic             res_valid;
	logic             res_ready;
	res_t             res;
	logic             out_valid_q;
	res_t             out_q;

	// ---- configuration port ----
	// register index is the word address; the low two bits are byte lanes
	assign reg_idx = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_wr && (reg_idx == REG_CAPACITY)) begin
			capacity_q <= pwdata[CAP_W-1:0];
		end
	end

	assign prdata = (reg_idx == REG_CAPACITY) ? PDATA_W'(capacity_q) : '0;

	// ---- pointer sequencer and ring memory ----
	bcdq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.capacity  (capacity_q),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.req_cmd   (req.cmd),
		.req_value (req.value),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// ---- output register ----
	// loads when empty or when its current result leaves this cycle
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.accepted    = out_q.accepted;
	assign rsp.front_value = out_q.front_value;
	assign rsp.rear_value  = out_q.rear_value;
	assign rsp.is_empty    = out_q.is_empty;
	assign rsp.is_full     = out_q.is_full;
	assign rsp.count       = out_q.count;

endmodule
`default_nettype wire

// ===== rtl/bcdq_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcdq_checker
// port-level checks of the deque, bound to the top level
// ----------------------------------------------------------------------------
module bcdq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic        rsp_accepted,
	input wire logic [31:0] rsp_front_value,
	input wire logic [31:0] rsp_rear_value,
	input wire logic        rsp_is_empty,
	input wire logic        rsp_is_full,
	input wire logic [4:0]  rsp_count
);

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accepted)
			&& $stable(rsp_front_value) && $stable(rsp_rear_value)
			&& $stable(rsp_is_empty) && $stable(rsp_is_full) && $stable(rsp_count))
		else $error("result changed while stalled");

	// empty deque reports zero count and -1 at both ends
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_is_empty |-> rsp_count == 5'd0
			&& rsp_front_value == 32'hFFFF_FFFF && rsp_rear_value == 32'hFFFF_FFFF)
		else $error("empty result inconsistent");

	// capacity is at least one, so empty and full never coincide
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_is_empty && rsp_is_full))
		else $error("empty and full together");

	// one request at a time: no request taken right after another
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while one is in flight");

endmodule

bind bounded_circular_deque bcdq_checker u_bcdq_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_accepted    (rsp.accepted),
	.rsp_front_value (rsp.front_value),
	.rsp_rear_value  (rsp.rear_value),
	.rsp_is_empty    (rsp.is_empty),
	.rsp_is_full     (rsp.is_full),
	.rsp_count       (rsp.count)
);
`default_nettype wire
